>>> rtl/pto_pkg.sv
`default_nettype none

package pto_pkg;

   localparam int QUANT_W = 8;
   localparam int COORD_W = 12;
   localparam int DIM_W   = 13;
   localparam int IDX_W   = 24;
   localparam int THR_W   = 16;
   localparam int SUM_W   = 10;
   localparam int LIM_W   = 27;
   localparam int NUM_W   = 33;
   localparam int DD_W    = 26;
   localparam int QBITS   = 7;
   localparam int CELL_W  = 8;

   localparam logic [QUANT_W-1:0] QUANTUM_MAX = 8'd255;
   localparam logic [SUM_W-1:0]   DEN_RGB     = 10'd765;
   localparam logic [SUM_W-1:0]   DEN_RGBA    = 10'd1020;
   localparam logic [NUM_W-1:0]   LHS100_K    = 33'd6553600;
   localparam logic [NUM_W-1:0]   FREE100_K   = 33'd76500;
   localparam logic [11:0]        RAW_RECIP   = 12'd2731;
   localparam int                 RAW_SHIFT   = 14;
   localparam logic [SUM_W-1:0]   RAW_SUM_MAX = 10'd301;
   localparam logic [7:0]         OCC_FULL    = 8'd100;
   localparam logic [CELL_W-1:0]  CELL_UNKNOWN = 8'hFF;

   localparam logic [1:0] MODE_TRINARY = 2'd0;
   localparam logic [1:0] MODE_SCALE   = 2'd1;
   localparam logic [1:0] MODE_RAW     = 2'd2;

   localparam logic [2:0] REG_CONV_MODE  = 3'd0;
   localparam logic [2:0] REG_NEGATE     = 3'd1;
   localparam logic [2:0] REG_FREE_THR   = 3'd2;
   localparam logic [2:0] REG_OCC_THR    = 3'd3;
   localparam logic [2:0] REG_HAS_ALPHA  = 3'd4;
   localparam logic [2:0] REG_MAP_WIDTH  = 3'd5;
   localparam logic [2:0] REG_MAP_HEIGHT = 3'd6;

   localparam logic [THR_W-1:0] FREE_THR_RST = 16'd12845;
   localparam logic [THR_W-1:0] OCC_THR_RST  = 16'd42598;
   localparam logic [DIM_W-1:0] MAX_DIM      = 13'd4096;

   typedef struct packed {
      logic [1:0]       conv_mode;
      logic             negate_shade;
      logic [THR_W-1:0] free_threshold;
      logic [THR_W-1:0] occupied_threshold;
      logic             image_has_alpha;
      logic [DIM_W-1:0] map_width;
      logic [DIM_W-1:0] map_height;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       conv_mode;
      logic             opac_nz;
      logic             occ_hit;
      logic             free_hit;
      logic             gap_zero;
      logic             raw_ok;
      logic [6:0]       raw_v;
      logic [IDX_W-1:0] cell_index;
   } side_type;

endpackage

`default_nettype wire

>>> rtl/pto_front.sv
`default_nettype none

module pto_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  pto_pkg::cfg_type       cfg,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire  [pto_pkg::QUANT_W-1:0]  red_level,
   input  wire  [pto_pkg::QUANT_W-1:0]  green_level,
   input  wire  [pto_pkg::QUANT_W-1:0]  blue_level,
   input  wire  [pto_pkg::QUANT_W-1:0]  opacity_level,
   input  wire  [pto_pkg::COORD_W-1:0] pixel_column,
   input  wire  [pto_pkg::COORD_W-1:0] pixel_row,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [pto_pkg::NUM_W-1:0]    out_num,
   output logic [pto_pkg::DD_W-1:0]     out_dd,
   output pto_pkg::side_type            out_side
);
   import pto_pkg::*;

   logic rdy1, rdy2, rdy3;

   // stage 1: sums, occupancy numerator, row flip
   logic               v1_ff;
   logic [1:0]         mode1_ff;
   logic               opac_nz1_ff;
   logic [SUM_W-1:0]   sum1_ff;
   logic [SUM_W-1:0]   occ1_ff;
   logic [SUM_W-1:0]   den1_ff;
   logic [IDX_W-1:0]   diff1_ff;
   logic [COORD_W-1:0] col1_ff;
   logic [THR_W-1:0]   tdiff1_ff;
   logic               gap1_ff;

   logic [SUM_W-1:0]   sum_in;
   logic [SUM_W-1:0]   den_in;
   logic               alpha_in;

   assign alpha_in = (cfg.conv_mode == MODE_TRINARY) && cfg.image_has_alpha;

   always_comb begin
      sum_in = SUM_W'(red_level) + SUM_W'(green_level) + SUM_W'(blue_level);
      den_in = DEN_RGB;
      if (alpha_in) begin
         sum_in = sum_in + SUM_W'(QUANTUM_MAX - opacity_level);
         den_in = DEN_RGBA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         mode1_ff    <= cfg.conv_mode;
         opac_nz1_ff <= (opacity_level != '0);
         sum1_ff     <= sum_in;
         occ1_ff     <= cfg.negate_shade ? sum_in : den_in - sum_in;
         den1_ff     <= den_in;
         diff1_ff    <= IDX_W'(cfg.map_height) - IDX_W'(pixel_row) - IDX_W'(1);
         col1_ff     <= pixel_column;
         tdiff1_ff   <= cfg.occupied_threshold - cfg.free_threshold;
         gap1_ff     <= (cfg.occupied_threshold <= cfg.free_threshold);
      end
   end

   // stage 2: products
   logic               v2_ff;
   logic [1:0]         mode2_ff;
   logic               opac_nz2_ff;
   logic               gap2_ff;
   logic [LIM_W-1:0]   lhs2_ff;
   logic [LIM_W-1:0]   occ_lim2_ff;
   logic [LIM_W-1:0]   free_lim2_ff;
   logic [NUM_W-1:0]   lhs100_2_ff;
   logic [NUM_W-1:0]   free100_2_ff;
   logic [DD_W-1:0]    dd2_ff;
   logic [IDX_W-1:0]   prod2_ff;
   logic [COORD_W-1:0] col2_ff;
   logic [6:0]         raw_v2_ff;
   logic               raw_ok2_ff;

   logic [22:0]        raw_prod_in;
   logic [IDX_W-1:0]   idx_prod_in;

   assign raw_prod_in = ({12'd0, sum1_ff, 1'b0} + 23'd3) * {11'd0, RAW_RECIP};
   assign idx_prod_in = IDX_W'(cfg.map_width) * diff1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         mode2_ff     <= mode1_ff;
         opac_nz2_ff  <= opac_nz1_ff;
         gap2_ff      <= gap1_ff;
         lhs2_ff      <= {1'b0, occ1_ff, 16'd0};
         occ_lim2_ff  <= LIM_W'(cfg.occupied_threshold) * LIM_W'(den1_ff);
         free_lim2_ff <= LIM_W'(cfg.free_threshold) * LIM_W'(den1_ff);
         lhs100_2_ff  <= NUM_W'(occ1_ff) * LHS100_K;
         free100_2_ff <= NUM_W'(cfg.free_threshold) * FREE100_K;
         dd2_ff       <= DD_W'(tdiff1_ff) * DD_W'(DEN_RGB);
         prod2_ff     <= idx_prod_in;
         col2_ff      <= col1_ff;
         raw_v2_ff    <= raw_prod_in[RAW_SHIFT+6:RAW_SHIFT];
         raw_ok2_ff   <= (sum1_ff <= RAW_SUM_MAX);
      end
   end

   // stage 3: threshold compares, interpolation numerator, index
   logic     v3_ff;
   side_type side3_ff;
   logic [NUM_W-1:0] num3_ff;
   logic [DD_W-1:0]  dd3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         side3_ff.conv_mode  <= mode2_ff;
         side3_ff.opac_nz    <= opac_nz2_ff;
         side3_ff.occ_hit    <= (occ_lim2_ff < lhs2_ff);
         side3_ff.free_hit   <= (lhs2_ff < free_lim2_ff);
         side3_ff.gap_zero   <= gap2_ff;
         side3_ff.raw_ok     <= raw_ok2_ff;
         side3_ff.raw_v      <= raw_v2_ff;
         side3_ff.cell_index <= prod2_ff + IDX_W'(col2_ff);
         num3_ff             <= lhs100_2_ff - free100_2_ff;
         dd3_ff              <= dd2_ff;
      end
   end

   assign rdy3      = !v3_ff || out_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign in_ready  = rdy1;
   assign out_valid = v3_ff;
   assign out_num   = num3_ff;
   assign out_dd    = dd3_ff;
   assign out_side  = side3_ff;

endmodule

`default_nettype wire

>>> rtl/pto_div.sv
`default_nettype none

module pto_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire  [pto_pkg::NUM_W-1:0]    in_num,
   input  wire  [pto_pkg::DD_W-1:0]     in_dd,
   input  wire  pto_pkg::side_type      in_side,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [pto_pkg::QBITS-1:0]    out_quo,
   output logic [pto_pkg::DD_W-1:0]     out_rem,
   output logic [pto_pkg::DD_W-1:0]     out_dd,
   output pto_pkg::side_type            out_side
);
   import pto_pkg::*;

   // one quotient bit per stage, most significant first
   logic [QBITS:0]   vx;
   logic [QBITS:0]   rdy;
   logic [NUM_W-1:0] remx [QBITS+1];
   logic [DD_W-1:0]  ddx  [QBITS+1];
   logic [QBITS-1:0] quox [QBITS+1];
   side_type         sidex[QBITS+1];

   assign vx[0]    = in_valid;
   assign remx[0]  = in_num;
   assign ddx[0]   = in_dd;
   assign quox[0]  = '0;
   assign sidex[0] = in_side;
   assign rdy[QBITS] = out_ready;

   for (genvar g = 0; g < QBITS; g++) begin : g_stage
      localparam int SH = QBITS - 1 - g;

      logic             v_ff;
      logic [NUM_W-1:0] rem_ff;
      logic [DD_W-1:0]  dd_ff;
      logic [QBITS-1:0] quo_ff;
      side_type         side_ff;

      logic [NUM_W-1:0] dsh;
      logic             hit;

      assign dsh = NUM_W'(ddx[g]) << SH;
      assign hit = (remx[g] >= dsh);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (rdy[g]) begin
            v_ff <= vx[g];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g]) begin
            rem_ff  <= hit ? remx[g] - dsh : remx[g];
            quo_ff  <= quox[g] | (QBITS'(hit) << SH);
            dd_ff   <= ddx[g];
            side_ff <= sidex[g];
         end
      end

      assign rdy[g]     = !v_ff || rdy[g+1];
      assign vx[g+1]    = v_ff;
      assign remx[g+1]  = rem_ff;
      assign ddx[g+1]   = dd_ff;
      assign quox[g+1]  = quo_ff;
      assign sidex[g+1] = side_ff;
   end

   assign in_ready  = rdy[0];
   assign out_valid = vx[QBITS];
   assign out_quo   = quox[QBITS];
   assign out_rem   = remx[QBITS][DD_W-1:0];
   assign out_dd    = ddx[QBITS];
   assign out_side  = sidex[QBITS];

endmodule

`default_nettype wire

>>> rtl/pto_back.sv
`default_nettype none

module pto_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire  [pto_pkg::QBITS-1:0]    in_quo,
   input  wire  [pto_pkg::DD_W-1:0]     in_rem,
   input  wire  [pto_pkg::DD_W-1:0]     in_dd,
   input  wire  pto_pkg::side_type      in_side,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [pto_pkg::CELL_W-1:0]   out_cell,
   output logic [pto_pkg::IDX_W-1:0]    out_index
);
   import pto_pkg::*;

   logic              v_ff;
   logic [CELL_W-1:0] cell_ff;
   logic [IDX_W-1:0]  index_ff;

   logic [DD_W:0]     two_rem;
   logic              round_up;
   logic [7:0]        interp;
   logic [CELL_W-1:0] cell_in;

   assign two_rem  = {in_rem, 1'b0};
   assign round_up = (two_rem > {1'b0, in_dd}) ||
                     ((two_rem == {1'b0, in_dd}) && in_quo[0]);
   assign interp   = 8'(in_quo) + 8'(round_up);

   always_comb begin
      cell_in = CELL_UNKNOWN;
      case (in_side.conv_mode)
         MODE_RAW: begin
            cell_in = in_side.raw_ok ? {1'b0, in_side.raw_v} : CELL_UNKNOWN;
         end
         MODE_TRINARY: begin
            if (in_side.occ_hit) begin
               cell_in = OCC_FULL;
            end else if (in_side.free_hit) begin
               cell_in = '0;
            end else begin
               cell_in = CELL_UNKNOWN;
            end
         end
         MODE_SCALE: begin
            if (in_side.opac_nz) begin
               cell_in = CELL_UNKNOWN;
            end else if (in_side.occ_hit) begin
               cell_in = OCC_FULL;
            end else if (in_side.free_hit || in_side.gap_zero) begin
               cell_in = '0;
            end else if (interp > OCC_FULL) begin
               cell_in = OCC_FULL;
            end else begin
               cell_in = interp;
            end
         end
         default: begin
            cell_in = CELL_UNKNOWN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         cell_ff  <= cell_in;
         index_ff <= in_side.cell_index;
      end
   end

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_cell  = cell_ff;
   assign out_index = index_ff;

endmodule

`default_nettype wire

>>> rtl/pixel_to_occupancy_cell.sv
// Map-image pixel to occupancy-grid cell.
// Input words arrive on req_*: red, green, blue, opacity, column and row of
// one pixel. Each word yields exactly one rsp_* word holding the cell value
// (-1 unknown, 0 free .. 100 occupied) and the row-flipped grid index.
// Mode, negate, thresholds, alpha flag and map size are set through csr_*,
// and the user must do so only while no pixel is in flight (the block does
// not enforce this); writes take effect on the next clock. From acceptance
// to rsp_tvalid a word passes three arithmetic stages, seven stages of
// restoring division (one quotient bit each) for the scale interpolation,
// and the output register. Throughput is one word per cycle while rsp_tready
// is high. Every stage has its own valid bit and ready term, so empty stages
// fill while rsp_tready is low; the block stops taking words only once all
// eleven stages hold a word, and nothing is lost or repeated across a stall.
// Synchronous reset empties the pipeline and restores the register defaults.
`default_nettype none

module pixel_to_occupancy_cell (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // red[7:0] green[15:8] blue[23:16] opacity[31:24] column[43:32] row[55:44]
   input  wire  [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // cell_value[7:0] cell_index[31:8]
   output logic [31:0] rsp_tdata,
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_wdata
);
   import pto_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CONV_MODE:  cfg_in.conv_mode          = csr_wdata[1:0];
            REG_NEGATE:     cfg_in.negate_shade       = csr_wdata[0];
            REG_FREE_THR:   cfg_in.free_threshold     = csr_wdata;
            REG_OCC_THR:    cfg_in.occupied_threshold = csr_wdata;
            REG_HAS_ALPHA:  cfg_in.image_has_alpha    = csr_wdata[0];
            REG_MAP_WIDTH:  cfg_in.map_width          = csr_wdata[DIM_W-1:0];
            REG_MAP_HEIGHT: cfg_in.map_height         = csr_wdata[DIM_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conv_mode          <= MODE_TRINARY;
         cfg_ff.negate_shade       <= 1'b0;
         cfg_ff.free_threshold     <= FREE_THR_RST;
         cfg_ff.occupied_threshold <= OCC_THR_RST;
         cfg_ff.image_has_alpha    <= 1'b0;
         cfg_ff.map_width          <= MAX_DIM;
         cfg_ff.map_height         <= MAX_DIM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   logic             f_valid, f_ready;
   logic [NUM_W-1:0] f_num;
   logic [DD_W-1:0]  f_dd;
   side_type         f_side;

   logic             d_valid, d_ready;
   logic [QBITS-1:0] d_quo;
   logic [DD_W-1:0]  d_rem;
   logic [DD_W-1:0]  d_dd;
   side_type         d_side;

   logic [CELL_W-1:0] cell_value;
   logic [IDX_W-1:0]  cell_index;

   pto_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .red_level     (req_tdata[7:0]),
      .green_level   (req_tdata[15:8]),
      .blue_level    (req_tdata[23:16]),
      .opacity_level (req_tdata[31:24]),
      .pixel_column  (req_tdata[43:32]),
      .pixel_row     (req_tdata[55:44]),
      .out_valid     (f_valid),
      .out_ready     (f_ready),
      .out_num       (f_num),
      .out_dd        (f_dd),
      .out_side      (f_side)
   );

   pto_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_num    (f_num),
      .in_dd     (f_dd),
      .in_side   (f_side),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_quo   (d_quo),
      .out_rem   (d_rem),
      .out_dd    (d_dd),
      .out_side  (d_side)
   );

   pto_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_quo    (d_quo),
      .in_rem    (d_rem),
      .in_dd     (d_dd),
      .in_side   (d_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_cell  (cell_value),
      .out_index (cell_index)
   );

   assign rsp_tdata = {cell_index, cell_value};

   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] == CELL_UNKNOWN || rsp_tdata[7:0] <= OCC_FULL))
      else $error("cell value out of range");

   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("word left in pipeline after reset");

endmodule

`default_nettype wire

>>> bench/occupancy_cell_checker.sv
`timescale 1ns / 100ps

module occupancy_cell_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   // red[7:0] green[15:8] blue[23:16] opacity[31:24] column[43:32] row[55:44]
   input  wire  [55:0] req_tdata,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   // cell_value[7:0] cell_index[31:8]
   input  wire  [31:0] rsp_tdata,
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_cells,
   output int          cells_checked
);
   import pto_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [CELL_W-1:0] value;
   } cell_word_type;

   cfg_type       map_cfg;
   cell_word_type expected_cells[$];
   cell_word_type seen_cell;
   cell_word_type want_cell;

   function automatic logic [CELL_W-1:0] shade_to_cell(input cfg_type c,
         input logic [7:0] red, input logic [7:0] green,
         input logic [7:0] blue, input logic [7:0] opac);
      logic [63:0] lum;
      logic [63:0] den;
      logic [63:0] occ;
      logic [63:0] lhs;
      logic [63:0] occ_lim;
      logic [63:0] free_lim;
      logic [63:0] num;
      logic [63:0] dd;
      logic [63:0] q;
      logic [63:0] r;
      lum = 64'(red) + 64'(green) + 64'(blue);
      case (c.conv_mode)
         MODE_RAW: begin
            num = lum * 64'd255;
            dd  = 64'd765;
            q   = (64'd2 * num + dd) / (64'd2 * dd);
            return (q <= 64'd100) ? q[7:0] : CELL_UNKNOWN;
         end
         MODE_TRINARY, MODE_SCALE: ;
         default: return CELL_UNKNOWN;
      endcase
      den = 64'd765;
      if (c.conv_mode == MODE_TRINARY && c.image_has_alpha) begin
         lum = lum + 64'(8'd255 - opac);
         den = 64'd1020;
      end
      occ      = c.negate_shade ? lum : den - lum;
      lhs      = occ << 16;
      occ_lim  = 64'(c.occupied_threshold) * den;
      free_lim = 64'(c.free_threshold) * den;
      if (c.conv_mode == MODE_SCALE && opac != 8'd0)
         return CELL_UNKNOWN;
      if (occ_lim < lhs)
         return OCC_FULL;
      if (lhs < free_lim)
         return 8'd0;
      if (c.conv_mode == MODE_TRINARY)
         return CELL_UNKNOWN;
      if (c.occupied_threshold <= c.free_threshold)
         return 8'd0;
      num = 64'd100 * (lhs - free_lim);
      dd  = 64'(c.occupied_threshold) - 64'(c.free_threshold);
      dd  = dd * den;
      q   = num / dd;
      r   = num % dd;
      // nearest, ties to even
      if (64'd2 * r > dd || (64'd2 * r == dd && q[0]))
         q = q + 64'd1;
      if (q > 64'd100)
         q = 64'd100;
      return q[7:0];
   endfunction

   function automatic logic [IDX_W-1:0] flipped_index(input cfg_type c,
         input logic [11:0] col, input logic [11:0] row);
      logic [63:0] span;
      span = 64'(c.map_height) - 64'(row) - 64'd1;
      span = span * 64'(c.map_width) + 64'(col);
      return span[IDX_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         map_cfg = '{MODE_TRINARY, 1'b0, FREE_THR_RST, OCC_THR_RST, 1'b0, MAX_DIM, MAX_DIM};
         expected_cells.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CONV_MODE:  map_cfg.conv_mode = csr_wdata[1:0];
               REG_NEGATE:     map_cfg.negate_shade = csr_wdata[0];
               REG_FREE_THR:   map_cfg.free_threshold = csr_wdata;
               REG_OCC_THR:    map_cfg.occupied_threshold = csr_wdata;
               REG_HAS_ALPHA:  map_cfg.image_has_alpha = csr_wdata[0];
               REG_MAP_WIDTH:  map_cfg.map_width = csr_wdata[DIM_W-1:0];
               REG_MAP_HEIGHT: map_cfg.map_height = csr_wdata[DIM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_cell = rsp_tdata;
            if (expected_cells.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected word: expected none, got value %0d index %0d",
                        $time, $signed(seen_cell.value), seen_cell.index);
            end else begin
               want_cell = expected_cells.pop_front();
               cells_checked++;
               if (seen_cell.value !== want_cell.value) begin
                  mismatch_count++;
                  $display("%0t cell_value: expected %0d, got %0d", $time,
                           $signed(want_cell.value), $signed(seen_cell.value));
               end
               if (seen_cell.index !== want_cell.index) begin
                  mismatch_count++;
                  $display("%0t cell_index: expected %0d, got %0d", $time,
                           want_cell.index, seen_cell.index);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want_cell.value = shade_to_cell(map_cfg, req_tdata[7:0], req_tdata[15:8],
                                            req_tdata[23:16], req_tdata[31:24]);
            want_cell.index = flipped_index(map_cfg, req_tdata[43:32], req_tdata[55:44]);
            expected_cells.insert(expected_cells.size(), want_cell);
         end
      end
      pending_cells = expected_cells.size();
   end

endmodule

>>> bench/tb_pixel_to_occupancy_cell.sv
`timescale 1ns / 100ps

module tb_pixel_to_occupancy_cell;
   import pto_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 120;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_ITEMS = 50;

   typedef enum int {RX_FLOW, RX_COIN, RX_SPARSE, RX_BEAT} rx_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [55:0] req_tdata = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int mismatch_count;
   int pending_cells;
   int cells_checked;

   int           burst_left = 0;
   int           pixels_sent = 0;
   int           settings_used = 0;
   int           quiet_cycles = 0;
   logic [12:0]  map_w = MAX_DIM;
   logic [12:0]  map_h = MAX_DIM;
   logic         hold_toggle = 1'b0;
   logic         hold_seen = 1'b0;
   rx_style_type rx_style = RX_FLOW;
   int           rx_count = 0;
   int           rx_beat = 0;

   pixel_to_occupancy_cell dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   occupancy_cell_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_cells  (pending_cells),
      .cells_checked  (cells_checked)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // receiver: own stall pattern, plus a long hold whenever the toggle flips
   initial begin
      forever begin
         @(posedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (rx_count == 0) begin
               rx_style = rx_style_type'($urandom_range(0, 3));
               rx_count = $urandom_range(8, 64);
            end
            rx_count--;
            rx_beat++;
            case (rx_style)
               RX_FLOW:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= (rx_beat % 5 != 0);
            endcase
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic set_map(input logic [1:0] mode, input logic neg, input logic [15:0] ft,
                          input logic [15:0] ot, input logic alpha,
                          input logic [12:0] w, input logic [12:0] h);
      write_reg(REG_CONV_MODE, 16'(mode));
      write_reg(REG_NEGATE, 16'(neg));
      write_reg(REG_FREE_THR, ft);
      write_reg(REG_OCC_THR, ot);
      write_reg(REG_HAS_ALPHA, 16'(alpha));
      write_reg(REG_MAP_WIDTH, 16'(w));
      write_reg(REG_MAP_HEIGHT, 16'(h));
      @(posedge clock);
      csr_we <= 1'b0;
      map_w = w;
      map_h = h;
      settings_used++;
   endtask

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [7:0] opac,
                             input logic [11:0] col, input logic [11:0] row);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {row, col, opac, blue, green, red};
      pixels_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait for every outstanding word
   task automatic await_cells();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_cells != 0);
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [11:0] pick_coord(input logic [12:0] span);
      if ($urandom_range(0, 7) == 0)
         return 12'($urandom_range(0, 4095));
      return 12'($urandom_range(0, span - 1));
   endfunction

   task automatic random_pixels(input int count);
      logic [7:0] opac;
      repeat (count) begin
         opac = ($urandom_range(0, 2) == 0) ? pick_level() : 8'd0;
         send_pixel(pick_level(), pick_level(), pick_level(), opac,
                    pick_coord(map_w), pick_coord(map_h));
      end
   endtask

   initial begin
      logic [1:0]  mode;
      logic [15:0] ft;
      logic [15:0] ot;
      logic [15:0] swap;
      logic [12:0] w;
      logic [12:0] h;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 12'd4095, 12'd4095);
      send_pixel(8'd128, 8'd128, 8'd128, 8'd0, 12'd2048, 12'd100);
      await_cells();

      // trinary with alpha in the mean, bright is occupied
      set_map(MODE_TRINARY, 1'b1, FREE_THR_RST, OCC_THR_RST, 1'b1, MAX_DIM, MAX_DIM);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 12'd1, 12'd2);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 12'd3, 12'd4);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd5, 12'd6);
      await_cells();

      // scale: transparency, both ends and interpolation
      set_map(MODE_SCALE, 1'b0, FREE_THR_RST, OCC_THR_RST, 1'b0, 13'd640, 13'd480);
      send_pixel(8'd10, 8'd20, 8'd30, 8'd1, 12'd7, 12'd8);
      send_pixel(8'd128, 8'd128, 8'd128, 8'd0, 12'd639, 12'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd479);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 12'd320, 12'd240);
      send_pixel(8'd100, 8'd100, 8'd100, 8'd0, 12'd9, 12'd10);
      await_cells();

      // scale with both thresholds at zero: white sits on both
      set_map(MODE_SCALE, 1'b0, 16'd0, 16'd0, 1'b0, 13'd640, 13'd480);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 12'd11, 12'd12);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd13, 12'd14);
      await_cells();

      // crossed thresholds, occupied test wins
      set_map(MODE_TRINARY, 1'b0, 16'd60000, 16'd1000, 1'b0, 13'd100, 13'd100);
      send_pixel(8'd128, 8'd128, 8'd128, 8'd0, 12'd15, 12'd16);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 12'd17, 12'd18);
      await_cells();

      // raw: zero, top of range and just past it
      set_map(MODE_RAW, 1'b0, FREE_THR_RST, OCC_THR_RST, 1'b0, MAX_DIM, MAX_DIM);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 12'd0, 12'd0);
      send_pixel(8'd101, 8'd100, 8'd100, 8'd0, 12'd19, 12'd20);
      send_pixel(8'd101, 8'd101, 8'd100, 8'd0, 12'd21, 12'd22);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 12'd23, 12'd24);
      await_cells();

      // spare mode code on a one-cell map, coordinates wrap the index
      set_map(MODE_SPARE, 1'b1, 16'd65535, 16'd0, 1'b1, 13'd1, 13'd1);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 12'd0, 12'd0);
      await_cells();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph % 3)
            0: mode = MODE_TRINARY;
            1: mode = MODE_SCALE;
            default: mode = MODE_RAW;
         endcase
         case (ph)
            0: begin ft = 16'd0;     ot = 16'd65535; end
            1: begin ft = 16'd65535; ot = 16'd65535; end
            2: begin ft = 16'd65535; ot = 16'd0;     end
            default: begin
               ft = 16'($urandom_range(0, 65535));
               ot = 16'($urandom_range(0, 65535));
               if (ft > ot && $urandom_range(0, 3) != 0) begin
                  swap = ft;
                  ft   = ot;
                  ot   = swap;
               end
            end
         endcase
         case (ph)
            2: begin w = 13'd1;  h = 13'd1;  end
            3: begin w = MAX_DIM; h = MAX_DIM; end
            5: begin w = MAX_DIM; h = 13'd1;  end
            default: begin
               w = 13'($urandom_range(1, 4096));
               h = 13'($urandom_range(1, 4096));
            end
         endcase
         set_map(mode, 1'($urandom_range(0, 1)), ft, ot, 1'($urandom_range(0, 1)), w, h);
         if (ph == 4)
            hold_toggle <= ~hold_toggle;
         random_pixels(PHASE_ITEMS);
         await_cells();
      end

      repeat (24) @(posedge clock);
      $display("run covered %0d pixels over %0d register settings, %0d cells checked,",
               pixels_sent, settings_used, cells_checked);
      $display("all modes incl. the spare code, threshold extremes and wrapped indices");
      if (mismatch_count == 0 && pending_cells == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
